// File: rtl/bbc_pkg.sv
// Shared types and constants for the bracket balance checker.
package bbc_pkg;

  localparam int OUT_POS_W   = 16;
  localparam int OUT_DEPTH_W = 11;

  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_CLOSE = 3'd1,
    ST_UNCLOSED  = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_ROUND  = 2'd1,
    KIND_SQUARE = 2'd2,
    KIND_CURLY  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [OUT_POS_W-1:0]   error_position;
    logic [OUT_DEPTH_W-1:0] final_depth;
  } out_item_t;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
    logic  last;
  } cmd_t;

endpackage

// File: rtl/bbc_front.sv
// Front end: accepts bytes, classifies brackets and tags each with its position.
module bbc_front #(
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  bbc_pkg::in_item_t        in_data,
  output logic                     q_push,
  output bbc_pkg::cmd_t            q_cmd,
  output logic [POSITION_BITS-1:0] q_pos,
  input  logic                     q_full
);
  import bbc_pkg::*;

  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] pos_nxt;
  cmd_t                     cmd;

  always_comb begin
    cmd      = '0;
    cmd.last = in_data.last;
    unique case (in_data.character)
      CH_OPEN_ROUND: begin
        cmd.is_open = 1'b1;
        cmd.kind    = KIND_ROUND;
      end
      CH_OPEN_SQUARE: begin
        cmd.is_open = 1'b1;
        cmd.kind    = KIND_SQUARE;
      end
      CH_OPEN_CURLY: begin
        cmd.is_open = 1'b1;
        cmd.kind    = KIND_CURLY;
      end
      CH_CLOSE_ROUND: begin
        cmd.is_close = 1'b1;
        cmd.kind     = KIND_ROUND;
      end
      CH_CLOSE_SQUARE: begin
        cmd.is_close = 1'b1;
        cmd.kind     = KIND_SQUARE;
      end
      CH_CLOSE_CURLY: begin
        cmd.is_close = 1'b1;
        cmd.kind     = KIND_CURLY;
      end
      default: begin
        cmd.kind = KIND_NONE;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_cmd    = cmd;
  assign q_pos    = pos_r;

  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      if (in_data.last) begin
        pos_nxt = '0;
      end else if (pos_r != '1) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// File: rtl/bbc_queue.sv
// Two-entry queue between the front end and the stack engine.
module bbc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r;
  logic             wr_ptr_nxt;
  logic             rd_ptr_r;
  logic             rd_ptr_nxt;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  property p_no_pop_when_empty;
    @(posedge clk) disable iff (!rst_n) pop |-> not_empty;
  endproperty
  a_no_pop_when_empty: assert property (p_no_pop_when_empty)
    else $error("queue popped while empty");

  property p_no_push_when_full;
    @(posedge clk) disable iff (!rst_n) push |-> !full;
  endproperty
  a_no_push_when_full: assert property (p_no_push_when_full)
    else $error("queue pushed while full");

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) count_r != 2'd3;
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("queue count out of range");

endmodule

// File: rtl/bbc_back.sv
// Stack engine: push, pop and match brackets, latch the first error, form the result.
module bbc_back #(
  parameter int STACK_DEPTH   = 1024,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  bbc_pkg::cmd_t            q_cmd,
  input  logic [POSITION_BITS-1:0] q_pos,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output bbc_pkg::out_item_t       out_data
);
  import bbc_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int EW = 2 + POSITION_BITS;

  logic [EW-1:0]            stack_mem [STACK_DEPTH];
  logic [EW-1:0]            below_r;
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic [CW-1:0]            count_calc;
  kind_t                    top_kind_r;
  kind_t                    top_kind_nxt;
  logic [POSITION_BITS-1:0] top_pos_r;
  logic [POSITION_BITS-1:0] top_pos_nxt;
  status_t                  err_r;
  status_t                  err_nxt;
  status_t                  err_calc;
  logic [POSITION_BITS-1:0] err_pos_r;
  logic [POSITION_BITS-1:0] err_pos_nxt;
  logic [POSITION_BITS-1:0] err_pos_calc;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  out_item_t                out_data_r;
  out_item_t                out_data_nxt;
  logic                     can_load;
  logic                     do_push;
  logic [AW-1:0]            rd_addr;

  assign can_load  = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && (!q_cmd.last || can_load);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    count_calc   = count_r;
    top_kind_nxt = top_kind_r;
    top_pos_nxt  = top_pos_r;
    err_calc     = err_r;
    err_pos_calc = err_pos_r;
    do_push      = 1'b0;
    if (q_pop && err_r == ST_OK) begin
      if (q_cmd.is_open) begin
        if (count_r == CW'(STACK_DEPTH)) begin
          err_calc     = ST_OVERFLOW;
          err_pos_calc = q_pos;
        end else begin
          do_push      = 1'b1;
          count_calc   = count_r + 1'b1;
          top_kind_nxt = q_cmd.kind;
          top_pos_nxt  = q_pos;
        end
      end else if (q_cmd.is_close) begin
        if (count_r == '0) begin
          err_calc     = ST_UNDERFLOW;
          err_pos_calc = q_pos;
        end else if (top_kind_r != q_cmd.kind) begin
          err_calc     = ST_BAD_CLOSE;
          err_pos_calc = q_pos;
        end else begin
          count_calc   = count_r - 1'b1;
          top_kind_nxt = kind_t'(below_r[EW-1 -: 2]);
          top_pos_nxt  = below_r[POSITION_BITS-1:0];
        end
      end
    end
    if (q_pop && q_cmd.last && err_calc == ST_OK && count_calc != '0) begin
      err_calc     = ST_UNCLOSED;
      err_pos_calc = top_pos_nxt;
    end
  end

  always_comb begin
    count_nxt     = count_calc;
    err_nxt       = err_calc;
    err_pos_nxt   = err_pos_calc;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (q_pop && q_cmd.last) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.status         = err_calc;
      out_data_nxt.error_position = (err_calc == ST_OK) ? '0 : OUT_POS_W'(err_pos_calc);
      out_data_nxt.final_depth    = OUT_DEPTH_W'(count_calc);
      count_nxt                   = '0;
      err_nxt                     = ST_OK;
      err_pos_nxt                 = '0;
    end
    rd_addr = AW'(count_nxt - CW'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      err_r       <= ST_OK;
      err_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      err_pos_r   <= err_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_kind_r <= top_kind_nxt;
    top_pos_r  <= top_pos_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_mem[AW'(count_r)] <= {q_cmd.kind, q_pos};
    end
    below_r <= stack_mem[rd_addr];
  end

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) count_r <= CW'(STACK_DEPTH);
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("stack count beyond depth");

  property p_frozen_after_error;
    @(posedge clk) disable iff (!rst_n)
      (err_r != ST_OK && !(q_pop && q_cmd.last)) |=> $stable(count_r);
  endproperty
  a_frozen_after_error: assert property (p_frozen_after_error)
    else $error("stack moved after an error was latched");

  property p_ok_has_zero_position;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_data_r.status == ST_OK) |-> out_data_r.error_position == '0;
  endproperty
  a_ok_has_zero_position: assert property (p_ok_has_zero_position)
    else $error("clean result carries an error position");

  property p_ok_means_empty;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_data_r.status == ST_OK) |-> out_data_r.final_depth == '0;
  endproperty
  a_ok_means_empty: assert property (p_ok_means_empty)
    else $error("clean result with brackets left open");

endmodule

// File: rtl/bracket_balance_checker.sv
// Top level of the bracket balance checker.
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one byte of a string
//   per transfer, with in_data.last set on the final byte. Brackets ( [ { open,
//   ) ] } close, every other byte only advances the position count.
//   The result channel (out_valid, out_stall, out_data) gives one transfer per
//   string, on its final byte: status, error position and final depth.
//   Throughput: one byte per cycle, set by the single write and single read
//   port of the stack memory and the top-of-stack register next to it, while no
//   held result stalls a final byte. The final byte is registered in the queue,
//   then the stack engine forms the result in the output register.
//   A two-entry queue parts the front end from the stack engine; while out_stall
//   holds a result, bytes that are not final keep flowing, and in_stall rises
//   once the queue fills.
//   Reset clears the stack count, position counter, latched error and queue;
//   the stack memory itself is not cleared, so no start-up pass is needed.
//   After each result the block clears itself for the next string.
module bracket_balance_checker #(
  parameter int STACK_DEPTH   = 1024,
  parameter int POSITION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bbc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bbc_pkg::out_item_t out_data
);
  import bbc_pkg::*;

  localparam int QW = $bits(cmd_t) + POSITION_BITS;

  logic                     f_push;
  cmd_t                     f_cmd;
  logic [POSITION_BITS-1:0] f_pos;
  logic                     q_full;
  logic                     q_valid;
  logic                     q_pop;
  logic [QW-1:0]            q_data;
  cmd_t                     b_cmd;
  logic [POSITION_BITS-1:0] b_pos;

  bbc_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (f_push),
    .q_cmd    (f_cmd),
    .q_pos    (f_pos),
    .q_full   (q_full)
  );

  bbc_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_cmd, f_pos}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  assign b_cmd = cmd_t'(q_data[QW-1 -: $bits(cmd_t)]);
  assign b_pos = q_data[POSITION_BITS-1:0];

  bbc_back #(
    .STACK_DEPTH  (STACK_DEPTH),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (b_cmd),
    .q_pos     (b_pos),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench for the bracket balance checker: directed table, long strings and random phrases.
module tb;
  import bbc_pkg::*;

  localparam int STACK_DEPTH  = 1024;
  localparam int NEST_DEPTH   = 64;
  localparam int LONG_HOLD    = 120;
  localparam int RANDOM_BYTES = 500;
  localparam int CALM_BYTES   = 80;

  typedef struct {
    logic [7:0] character;
    logic       last;
    bit         typed;
    out_item_t  want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  kind_t       open_kind [STACK_DEPTH];
  logic [15:0] open_pos  [STACK_DEPTH];
  int          depth    = 0;
  logic [15:0] pos_ctr  = '0;
  status_t     err_code = ST_OK;
  logic [15:0] err_pos  = '0;

  out_item_t  verdict_q [$];
  logic [7:0] text_q [$];
  int         errors   = 0;
  bit         calm     = 1'b0;
  bit         hold_req = 1'b0;

  row_t script [25] = '{
    '{CH_OPEN_ROUND,   1'b0, 1'b0, '0},
    '{CH_CLOSE_ROUND,  1'b1, 1'b1, '{ST_OK, 16'd0, 11'd0}},
    '{CH_CLOSE_ROUND,  1'b1, 1'b1, '{ST_UNDERFLOW, 16'd0, 11'd0}},
    '{CH_OPEN_ROUND,   1'b0, 1'b0, '0},
    '{CH_CLOSE_CURLY,  1'b1, 1'b1, '{ST_BAD_CLOSE, 16'd1, 11'd1}},
    '{CH_OPEN_CURLY,   1'b0, 1'b0, '0},
    '{CH_OPEN_SQUARE,  1'b1, 1'b1, '{ST_UNCLOSED, 16'd1, 11'd2}},
    '{8'h00,           1'b0, 1'b0, '0},
    '{8'hFF,           1'b1, 1'b1, '{ST_OK, 16'd0, 11'd0}},
    '{CH_OPEN_SQUARE,  1'b0, 1'b0, '0},
    '{CH_OPEN_CURLY,   1'b0, 1'b0, '0},
    '{8'h61,           1'b0, 1'b0, '0},
    '{CH_CLOSE_CURLY,  1'b0, 1'b0, '0},
    '{CH_CLOSE_SQUARE, 1'b0, 1'b0, '0},
    '{CH_OPEN_ROUND,   1'b0, 1'b0, '0},
    '{CH_CLOSE_ROUND,  1'b1, 1'b0, '0},
    '{CH_CLOSE_SQUARE, 1'b0, 1'b0, '0},
    '{CH_OPEN_ROUND,   1'b0, 1'b0, '0},
    '{CH_CLOSE_ROUND,  1'b1, 1'b0, '0},
    '{CH_OPEN_ROUND,   1'b0, 1'b0, '0},
    '{CH_OPEN_SQUARE,  1'b0, 1'b0, '0},
    '{CH_CLOSE_ROUND,  1'b0, 1'b0, '0},
    '{CH_CLOSE_SQUARE, 1'b1, 1'b0, '0},
    '{8'hAA,           1'b0, 1'b0, '0},
    '{CH_OPEN_CURLY,   1'b1, 1'b0, '0}
  };

  bracket_balance_checker u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit scan_byte(input in_item_t it, output out_item_t verdict);
    kind_t opens;
    kind_t closes;
    opens   = KIND_NONE;
    closes  = KIND_NONE;
    verdict = '0;
    case (it.character)
      CH_OPEN_ROUND:   opens  = KIND_ROUND;
      CH_OPEN_SQUARE:  opens  = KIND_SQUARE;
      CH_OPEN_CURLY:   opens  = KIND_CURLY;
      CH_CLOSE_ROUND:  closes = KIND_ROUND;
      CH_CLOSE_SQUARE: closes = KIND_SQUARE;
      CH_CLOSE_CURLY:  closes = KIND_CURLY;
      default: ;
    endcase
    if (err_code == ST_OK) begin
      if (opens != KIND_NONE) begin
        if (depth >= STACK_DEPTH) begin
          err_code = ST_OVERFLOW;
          err_pos  = pos_ctr;
        end else begin
          open_kind[depth] = opens;
          open_pos[depth]  = pos_ctr;
          depth++;
        end
      end else if (closes != KIND_NONE) begin
        if (depth == 0) begin
          err_code = ST_UNDERFLOW;
          err_pos  = pos_ctr;
        end else if (open_kind[depth-1] != closes) begin
          err_code = ST_BAD_CLOSE;
          err_pos  = pos_ctr;
        end else begin
          depth--;
        end
      end
    end
    if (pos_ctr != 16'hFFFF) pos_ctr++;
    if (!it.last) return 1'b0;
    if (err_code == ST_OK && depth > 0) begin
      err_code = ST_UNCLOSED;
      err_pos  = open_pos[depth-1];
    end
    verdict.status         = err_code;
    verdict.error_position = (err_code == ST_OK) ? '0 : err_pos;
    verdict.final_depth    = OUT_DEPTH_W'(depth);
    depth    = 0;
    pos_ctr  = '0;
    err_code = ST_OK;
    err_pos  = '0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] bracket(input kind_t k, input bit closing);
    case (k)
      KIND_ROUND:  return closing ? CH_CLOSE_ROUND  : CH_OPEN_ROUND;
      KIND_SQUARE: return closing ? CH_CLOSE_SQUARE : CH_OPEN_SQUARE;
      default:     return closing ? CH_CLOSE_CURLY  : CH_OPEN_CURLY;
    endcase
  endfunction

  function automatic logic [7:0] filler();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c inside {CH_OPEN_ROUND, CH_OPEN_SQUARE, CH_OPEN_CURLY,
                  CH_CLOSE_ROUND, CH_CLOSE_SQUARE, CH_CLOSE_CURLY})
      c = c ^ 8'h80;
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic last, input bit typed,
                           input out_item_t want);
    in_item_t  it;
    out_item_t verdict;
    it.character = ch;
    it.last      = last;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (scan_byte(it, verdict)) verdict_q.push_back(typed ? want : verdict);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1, 1'b0, '0);
  endtask

  task automatic drain_results();
    if (verdict_q.size() != 0) begin
      in_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    kind_t pend [$];
    kind_t k;
    int    sent;
    int    len;
    int    r;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i])
      send_byte(script[i].character, script[i].last, script[i].typed, script[i].want);

    // nest deeply, then drain
    text_q.delete();
    pend.delete();
    repeat (NEST_DEPTH) begin
      k = kind_t'($urandom_range(1, 3));
      pend.push_back(k);
      text_q.push_back(bracket(k, 1'b0));
    end
    while (pend.size() != 0) text_q.push_back(bracket(pend.pop_back(), 1'b1));
    send_text();

    drain_results();

    hold_req = 1'b1;
    sent     = 0;
    while (sent < RANDOM_BYTES) begin
      if (sent >= RANDOM_BYTES - CALM_BYTES) calm = 1'b1;
      text_q.delete();
      pend.delete();
      len = $urandom_range(1, 16);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          k = kind_t'($urandom_range(1, 3));
          pend.push_back(k);
          text_q.push_back(bracket(k, 1'b0));
        end else if (r < 65 && pend.size() != 0) begin
          text_q.push_back(bracket(pend.pop_back(), 1'b1));
        end else if (r < 72) begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          text_q.push_back(filler());
        end
      end
      if ($urandom_range(0, 4) != 0)
        while (pend.size() != 0) text_q.push_back(bracket(pend.pop_back(), 1'b1));
      sent += text_q.size();
      send_text();
      if (sent >= RANDOM_BYTES / 2 && sent - text_q.size() < RANDOM_BYTES / 2)
        drain_results();
    end

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && rst_n && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, out_data);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data.status != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_data.status);
          errors++;
        end
        if (out_data.error_position != want.error_position) begin
          $display("%0t: error_position expected %0d actual %0d", $time,
                   want.error_position, out_data.error_position);
          errors++;
        end
        if (out_data.final_depth != want.final_depth) begin
          $display("%0t: final_depth expected %0d actual %0d", $time,
                   want.final_depth, out_data.final_depth);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
